@@ rtl/core/rfr_pkg.sv @@
// Shared constants, register codes and types of the row FIR filter.
package rfr_pkg;

  localparam int DEF_MAX_RADIUS  = 3;
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int DIM_BITS       = 13;
  localparam int RAD_BITS       = 2;
  localparam int TAP_BITS       = 16;
  localparam int TAP_COUNT      = 7;
  localparam int TAP_FRAC       = 14;
  localparam int SUM_GUARD      = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int TAPS_LO_COUNT  = 4;
  localparam int TAPS_HI_COUNT  = TAP_COUNT - TAPS_LO_COUNT;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_FIRST  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_LAST   = 3'd4;

  localparam logic [DIM_BITS-1:0] RST_ROW_WIDTH = 13'd64;
  localparam logic [DIM_BITS-1:0] RST_ROW_COUNT = 13'd64;
  localparam logic [RAD_BITS-1:0] RST_RADIUS    = 2'd0;
  localparam logic [TAP_BITS-1:0] RST_TAP_ZERO  = 16'd16384;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } mark_t;

  typedef logic [TAP_COUNT-1:0][TAP_BITS-1:0] taps_t;

endpackage

@@ rtl/core/rfr_if.sv @@
// Stream interfaces for samples into and results out of the row FIR filter.
interface rfr_sample_if import rfr_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, sample_in, input ready);
  modport sink   (input valid, sample_in, output ready);
endinterface

interface rfr_result_if import rfr_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          clipped;
  logic                          row_end;
  logic                          frame_end;

  modport source (output valid, filtered, clipped, row_end, frame_end, input ready);
  modport sink   (input valid, filtered, clipped, row_end, frame_end, output ready);
endinterface

@@ rtl/core/rfr_window.sv @@
// Sample window, column and row tracking, and row-end flush sequencing.
module rfr_window import rfr_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [SAMPLE_BITS-1:0]                  in_sample,
  input  logic [DIM_BITS-1:0]                     row_width,
  input  logic [DIM_BITS-1:0]                     row_count,
  input  logic [RAD_BITS-1:0]                     kernel_radius,
  output logic                                    em_valid,
  input  logic                                    em_ready,
  output logic [2*MAX_RADIUS:0][SAMPLE_BITS-1:0]  em_window,
  output logic [RAD_BITS-1:0]                     em_radius,
  output mark_t                                   em_mark
);

  localparam int WIN      = 2 * MAX_RADIUS + 1;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int CMP_BITS = (W_BITS > DIM_BITS) ? W_BITS : DIM_BITS;
  localparam int COLX     = COL_BITS + 1;
  localparam int ROWX     = DIM_BITS + 1;
  localparam logic [CMP_BITS-1:0] WIDTH_CAP = CMP_BITS'(MAX_WIDTH);
  localparam logic [RAD_BITS-1:0] RAD_CAP   = RAD_BITS'(MAX_RADIUS);

  logic [WIN-1:0][SAMPLE_BITS-1:0] window, window_next;
  logic [COL_BITS-1:0]             col, col_next;
  logic [DIM_BITS-1:0]             row, row_next;
  logic [RAD_BITS-1:0]             rad, rad_next;
  logic                            flushing, flushing_next;
  logic [RAD_BITS-1:0]             fl_k, fl_k_next;
  logic [SAMPLE_BITS-1:0]          fl_sample, fl_sample_next;
  logic [COL_BITS-1:0]             fl_col, fl_col_next;
  logic                            fl_fend, fl_fend_next;

  logic [CMP_BITS-1:0] width_ext, width_eff;
  logic [DIM_BITS-1:0] count_eff;
  logic [RAD_BITS-1:0] rad_new, r_use;
  logic                last_col, frame_last, in_fire;

  always_comb begin
    width_ext = CMP_BITS'(row_width);
    if (width_ext == '0) begin
      width_eff = CMP_BITS'(1);
    end else if (width_ext > WIDTH_CAP) begin
      width_eff = WIDTH_CAP;
    end else begin
      width_eff = width_ext;
    end
    count_eff  = (row_count == '0) ? DIM_BITS'(1) : row_count;
    rad_new    = (kernel_radius > RAD_CAP) ? RAD_CAP : kernel_radius;
    r_use      = (col == '0) ? rad_new : rad;
    last_col   = (CMP_BITS'(col) + CMP_BITS'(1)) >= width_eff;
    frame_last = (ROWX'(row) + ROWX'(1)) >= ROWX'(count_eff);

    in_ready = !flushing && em_ready;
    in_fire  = in_valid && in_ready;

    window_next    = window;
    col_next       = col;
    row_next       = row;
    rad_next       = rad;
    flushing_next  = flushing;
    fl_k_next      = fl_k;
    fl_sample_next = fl_sample;
    fl_col_next    = fl_col;
    fl_fend_next   = fl_fend;
    em_valid       = 1'b0;
    em_radius      = rad;
    em_mark        = '0;

    if (in_fire) begin
      if (col == '0) begin
        window_next = {WIN{in_sample}};
      end else begin
        window_next = {window[WIN-2:0], in_sample};
      end
      rad_next          = r_use;
      em_radius         = r_use;
      em_valid          = COLX'(col) >= COLX'(r_use);
      em_mark.row_end   = last_col && (r_use == '0);
      em_mark.frame_end = last_col && (r_use == '0) && frame_last;
      if (last_col) begin
        col_next = '0;
        row_next = frame_last ? '0 : row + DIM_BITS'(1);
        if (r_use != '0) begin
          flushing_next  = 1'b1;
          fl_k_next      = RAD_BITS'(1);
          fl_sample_next = in_sample;
          fl_col_next    = col;
          fl_fend_next   = frame_last;
        end
      end else begin
        col_next = col + COL_BITS'(1);
      end
    end else if (flushing && em_ready) begin
      // replicate the last sample past the right edge
      window_next       = {window[WIN-2:0], fl_sample};
      em_valid          = (COLX'(fl_col) + COLX'(fl_k)) >= COLX'(rad);
      em_mark.row_end   = fl_k == rad;
      em_mark.frame_end = (fl_k == rad) && fl_fend;
      if (fl_k == rad) begin
        flushing_next = 1'b0;
      end else begin
        fl_k_next = fl_k + RAD_BITS'(1);
      end
    end
    em_window = window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      rad      <= '0;
      flushing <= 1'b0;
      fl_k     <= '0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      rad      <= rad_next;
      flushing <= flushing_next;
      fl_k     <= fl_k_next;
    end
  end

  always_ff @(posedge clk) begin
    window    <= window_next;
    fl_sample <= fl_sample_next;
    fl_col    <= fl_col_next;
    fl_fend   <= fl_fend_next;
  end

endmodule

@@ rtl/core/rfr_mac.sv @@
// Tap multiply stage and product sum stage.
module rfr_mac import rfr_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          em_valid,
  output logic                                          em_ready,
  input  logic [2*MAX_RADIUS:0][SAMPLE_BITS-1:0]        em_window,
  input  logic [RAD_BITS-1:0]                           em_radius,
  input  mark_t                                         em_mark,
  input  taps_t                                         taps,
  output logic                                          sum_valid,
  input  logic                                          sum_ready,
  output logic signed [SAMPLE_BITS+TAP_BITS+SUM_GUARD-1:0] sum,
  output mark_t                                         sum_mark
);

  localparam int WIN       = 2 * MAX_RADIUS + 1;
  localparam int IDX_BITS  = $clog2(WIN);
  localparam int PROD_BITS = SAMPLE_BITS + TAP_BITS;
  localparam int SUM_BITS  = PROD_BITS + SUM_GUARD;

  logic [WIN-1:0][SAMPLE_BITS-1:0] operand;
  logic [WIN-1:0][PROD_BITS-1:0]   prod, prod_next;
  logic signed [SUM_BITS-1:0]      sum_next;
  logic [IDX_BITS-1:0]             idx;
  logic                            prod_valid, stage2_ready;
  mark_t                           prod_mark;

  always_comb begin
    idx = '0;
    for (int t = 0; t < WIN; t++) begin
      operand[t] = '0;
      if (t <= 2 * int'(em_radius)) begin
        idx        = IDX_BITS'(2 * int'(em_radius) - t);
        operand[t] = em_window[idx];
      end
      prod_next[t] = PROD_BITS'($signed(operand[t]) * $signed(taps[t]));
    end
  end

  always_comb begin
    sum_next = '0;
    for (int t = 0; t < WIN; t++) begin
      sum_next = sum_next + SUM_BITS'($signed(prod[t]));
    end
  end

  assign stage2_ready = !sum_valid || sum_ready;
  assign em_ready     = !prod_valid || stage2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
    end else begin
      if (em_ready) begin
        prod_valid <= em_valid;
      end
      if (stage2_ready) begin
        sum_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready && em_valid) begin
      prod      <= prod_next;
      prod_mark <= em_mark;
    end
    if (stage2_ready && prod_valid) begin
      sum      <= sum_next;
      sum_mark <= prod_mark;
    end
  end

endmodule

@@ rtl/core/rfr_round.sv @@
// Round to nearest, saturate and hold the result register.
module rfr_round import rfr_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             sum_valid,
  output logic                                             sum_ready,
  input  logic signed [SAMPLE_BITS+TAP_BITS+SUM_GUARD-1:0] sum,
  input  mark_t                                            sum_mark,
  rfr_result_if.source                                     results
);

  localparam int SUM_BITS = SAMPLE_BITS + TAP_BITS + SUM_GUARD;
  localparam int Q_BITS   = SUM_BITS - TAP_FRAC;
  localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) <<< (TAP_FRAC - 1);
  localparam logic signed [Q_BITS-1:0] HI =
    {{(Q_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [Q_BITS-1:0] LO =
    {{(Q_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SUM_BITS-1:0]    rnd;
  logic signed [Q_BITS-1:0]      q;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          clip;

  always_comb begin
    rnd = sum + HALF;
    q   = rnd[SUM_BITS-1:TAP_FRAC];
    if (q > HI) begin
      sat  = HI[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (q < LO) begin
      sat  = LO[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else begin
      sat  = q[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

  assign sum_ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (sum_ready) begin
      results.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      results.filtered  <= sat;
      results.clipped   <= clip;
      results.row_end   <= sum_mark.row_end;
      results.frame_end <= sum_mark.frame_end;
    end
  end

endmodule

@@ rtl/core/row_fir_replicate_edge.sv @@
// Horizontal FIR filter with replicated row borders: top level and registers.
//
//   channel   dir   handshake      payload
//   samples   in    valid/ready    sample_in (signed Q1.15)
//   results   out   valid/ready    filtered, clipped, row_end, frame_end
//   cfg       in    cfg_write      cfg_index, cfg_data
//
// One sample per cycle while no flush runs and the output does not stall; a result
// passes the product, sum and result registers in turn after its request is taken.
// The last sample of a row with radius r > 0 holds off input while the flush
// replays the edge sample through the window.
// Reset loads the register defaults and clears all valids; no clearing pass.
// A stalled output backs up through the pipeline to samples.ready.
module row_fir_replicate_edge import rfr_pkg::*; #(
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  rfr_sample_if.sink                samples,
  rfr_result_if.source              results,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int WIN      = 2 * MAX_RADIUS + 1;
  localparam int SUM_BITS = SAMPLE_BITS + TAP_BITS + SUM_GUARD;

  logic [DIM_BITS-1:0] row_width;
  logic [DIM_BITS-1:0] row_count;
  logic [RAD_BITS-1:0] kernel_radius;
  taps_t               taps;

  logic                            em_valid, em_ready;
  logic [WIN-1:0][SAMPLE_BITS-1:0] em_window;
  logic [RAD_BITS-1:0]             em_radius;
  mark_t                           em_mark;
  logic                            sum_valid, sum_ready;
  logic signed [SUM_BITS-1:0]      sum;
  mark_t                           sum_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= RST_ROW_WIDTH;
      row_count     <= RST_ROW_COUNT;
      kernel_radius <= RST_RADIUS;
      taps          <= {{((TAP_COUNT - 1) * TAP_BITS){1'b0}}, RST_TAP_ZERO};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_WIDTH:  row_width     <= cfg_data[DIM_BITS-1:0];
        REG_ROW_COUNT:  row_count     <= cfg_data[DIM_BITS-1:0];
        REG_RADIUS:     kernel_radius <= cfg_data[RAD_BITS-1:0];
        REG_TAPS_FIRST: taps[TAPS_LO_COUNT-1:0] <= cfg_data[TAPS_LO_COUNT*TAP_BITS-1:0];
        REG_TAPS_LAST:  taps[TAP_COUNT-1:TAPS_LO_COUNT] <=
                          cfg_data[TAPS_HI_COUNT*TAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  rfr_window #(
    .MAX_RADIUS  (MAX_RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .in_sample     (samples.sample_in),
    .row_width     (row_width),
    .row_count     (row_count),
    .kernel_radius (kernel_radius),
    .em_valid      (em_valid),
    .em_ready      (em_ready),
    .em_window     (em_window),
    .em_radius     (em_radius),
    .em_mark       (em_mark)
  );

  rfr_mac #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .em_valid  (em_valid),
    .em_ready  (em_ready),
    .em_window (em_window),
    .em_radius (em_radius),
    .em_mark   (em_mark),
    .taps      (taps),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .sum_mark  (sum_mark)
  );

  rfr_round #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .sum_mark  (sum_mark),
    .results   (results)
  );

endmodule

@@ verif/tb_top.sv @@
// Testbench of the row FIR filter: directed and random rasters checked against a predictor.
module tb_top;
  import rfr_pkg::*;

  localparam int SB             = DEF_SAMPLE_BITS;
  localparam int WIN            = 2 * DEF_MAX_RADIUS + 1;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_SAMPLES = 400;
  localparam longint S_HI       = (longint'(1) << (SB - 1)) - 1;
  localparam longint S_LO       = -S_HI - 1;

  typedef struct packed {
    logic signed [SB-1:0] filtered;
    logic                 clipped;
    mark_t                marks;
  } filt_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  rfr_sample_if #(.SAMPLE_BITS(SB)) smp ();
  rfr_result_if #(.SAMPLE_BITS(SB)) res ();

  row_fir_replicate_edge #(.SAMPLE_BITS(SB)) i_dut (
    .clk(clk), .rst(rst), .samples(smp), .results(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [DIM_BITS-1:0]  width_reg  = RST_ROW_WIDTH;
  logic [DIM_BITS-1:0]  count_reg  = RST_ROW_COUNT;
  logic [RAD_BITS-1:0]  rad_reg    = RST_RADIUS;
  logic [63:0]          taps_first = 64'(RST_TAP_ZERO);
  logic [47:0]          taps_last  = '0;
  logic signed [SB-1:0] window [WIN];
  int                   in_col, row_idx, row_rad;

  logic [SB-1:0] sample_q [$];
  filt_t         filtered_q [$];
  int            queued_n, taken_n, cycle_n, errors;
  logic          sample_taken, calm;
  int            src_gap, sink_gap;
  filt_t         got, want;

  function automatic void shift_window(logic signed [SB-1:0] s);
    for (int i = WIN - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = s;
  endfunction

  function automatic void emit_filtered(int r, logic row_last, logic frame_last);
    logic [TAP_COUNT*TAP_BITS-1:0] tap_bits;
    logic signed [TAP_BITS-1:0]    tap;
    longint                        acc;
    filt_t                         f;
    tap_bits = {taps_last, taps_first};
    acc = 0;
    for (int t = 0; t <= 2 * r; t++) begin
      tap = tap_bits[TAP_BITS*t +: TAP_BITS];
      acc += longint'(window[2 * r - t]) * longint'(tap);
    end
    acc = (acc + (longint'(1) << (TAP_FRAC - 1))) >>> TAP_FRAC;
    f.clipped = 1'b1;
    if (acc > S_HI) acc = S_HI;
    else if (acc < S_LO) acc = S_LO;
    else f.clipped = 1'b0;
    f.filtered        = acc[SB-1:0];
    f.marks.row_end   = row_last;
    f.marks.frame_end = frame_last;
    filtered_q.push_back(f);
  endfunction

  function automatic void filter_sample(logic signed [SB-1:0] s);
    int   w, rc, c, r;
    logic frame_last;
    w = (width_reg == 0) ? 1 : int'(width_reg);
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    rc = (count_reg == 0) ? 1 : int'(count_reg);
    c = in_col;
    if (c == 0) begin
      row_rad = int'(rad_reg);
      foreach (window[i]) window[i] = s;
    end else begin
      shift_window(s);
    end
    r = row_rad;
    if (c + 1 >= w) begin
      frame_last = (row_idx + 1 >= rc);
      for (int k = 0; k <= r; k++) begin
        if (k > 0) shift_window(s);
        if (c - r + k >= 0) emit_filtered(r, k == r, (k == r) && frame_last);
      end
      in_col = 0;
      row_idx = frame_last ? 0 : row_idx + 1;
    end else begin
      if (c >= r) emit_filtered(r, 1'b0, 1'b0);
      in_col = c + 1;
    end
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    logic [SB-1:0] edges [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    case ($urandom_range(0, 5))
      0: return edges[$urandom_range(0, 4)];
      1: return SB'($urandom_range(0, 512) - 256);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_taps(logic gentle);
    logic [TAP_BITS-1:0] edges [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                       16'h4000, 16'hC000};
    logic [63:0]         word;
    for (int i = 0; i < 4; i++) begin
      if (gentle) word[16*i +: 16] = 16'($urandom_range(0, 8192) - 4096);
      else if ($urandom_range(0, 2) == 0) word[16*i +: 16] = edges[$urandom_range(0, 5)];
      else word[16*i +: 16] = 16'($urandom);
    end
    return word;
  endfunction

  task automatic queue_samples(int n);
    repeat (n) sample_q.push_back(pick_sample());
    queued_n += n;
  endtask

  task automatic queue_value(logic [SB-1:0] v);
    sample_q.push_back(v);
    queued_n++;
  endtask

  // wait until every request is taken and every result is back, then let the pipe empty
  task automatic settle();
    while (taken_n != queued_n || filtered_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_config(int w, int c, int r, logic [63:0] tf, logic [47:0] tl);
    logic [CFG_INDEX_BITS-1:0] regs [5];
    logic [CFG_DATA_BITS-1:0]  vals [5];
    regs = '{REG_ROW_WIDTH, REG_ROW_COUNT, REG_RADIUS, REG_TAPS_FIRST, REG_TAPS_LAST};
    vals = '{CFG_DATA_BITS'(w), CFG_DATA_BITS'(c), CFG_DATA_BITS'(r),
             CFG_DATA_BITS'(tf), CFG_DATA_BITS'(tl)};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    width_reg  = DIM_BITS'(w);
    count_reg  = DIM_BITS'(c);
    rad_reg    = RAD_BITS'(r);
    taps_first = tf;
    taps_last  = tl;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (!smp.valid || sample_taken) begin
      if (src_gap == 0 && !calm && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 8);
      if (src_gap > 0) begin
        src_gap--;
        smp.valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        smp.sample_in <= sample_q.pop_front();
        smp.valid     <= 1'b1;
      end else begin
        smp.valid <= 1'b0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (sink_gap == 0 && !calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 8);
    if (sink_gap > 0) begin
      sink_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    sample_taken = 1'b0;
    if (!rst) begin
      cycle_n++;
      if (cycle_n > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        if (smp.valid && smp.ready) begin
          sample_taken = 1'b1;
          taken_n++;
          filter_sample(smp.sample_in);
        end
        if (res.valid && res.ready) begin
          got.filtered        = res.filtered;
          got.clipped         = res.clipped;
          got.marks.row_end   = res.row_end;
          got.marks.frame_end = res.frame_end;
          if (filtered_q.size() == 0) begin
            errors++;
            if (errors <= 40)
              $display("%0t: unexpected result %0d clip %b row_end %b frame_end %b", $time,
                       got.filtered, got.clipped, got.marks.row_end, got.marks.frame_end);
          end else begin
            want = filtered_q.pop_front();
            if (got !== want) begin
              errors++;
              if (errors <= 40)
                $display("%0t: expected %0d clip %b row_end %b frame_end %b, got %0d %b %b %b",
                         $time, want.filtered, want.clipped, want.marks.row_end,
                         want.marks.frame_end, got.filtered, got.clipped,
                         got.marks.row_end, got.marks.frame_end);
            end
          end
        end
      end
    end
  end

  initial begin
    int          rand_n, phase_n, w, eff, n;
    logic        gentle;
    logic [63:0] tf, tl;
    rst           = 1'b1;
    smp.valid     = 1'b0;
    smp.sample_in = '0;
    res.ready     = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    foreach (window[i]) window[i] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // smoothing kernel over sample extremes
    load_config(5, 1, 1, {16'd0, 16'd8192, 16'd16384, 16'd8192}, 48'd0);
    queue_value(16'h7FFF); queue_value(16'h8000); queue_value(16'h0000);
    queue_value(16'h0001); queue_value(16'hFFFF);
    settle();

    // saturation both ways, rows no wider than the radius
    load_config(3, 1, 3, {4{16'h7FFF}}, {3{16'h7FFF}});
    repeat (3) queue_value(16'h7FFF);
    repeat (3) queue_value(16'h8000);
    settle();
    load_config(2, 1, 3, {4{16'h8000}}, {3{16'h8000}});
    repeat (2) queue_value(16'h8000);
    settle();

    // zero width and count act as one; rounding ties go up
    load_config(0, 0, 0, 64'd1, 48'd0);
    queue_value(16'd8192); queue_value(-16'sd8192);
    queue_value(16'd24576); queue_value(-16'sd24576);
    settle();

    // width, radius and taps changed mid-row
    load_config(4096, 3, 2, pick_taps(1'b0), 48'(pick_taps(1'b0)));
    queue_samples(4);
    settle();
    load_config(2, 3, 1, pick_taps(1'b1), 48'(pick_taps(1'b1)));
    queue_samples(4);

    rand_n  = 0;
    phase_n = 0;
    while (rand_n < RANDOM_SAMPLES) begin
      settle();
      phase_n++;
      case ($urandom_range(0, 9))
        0: w = 1;
        1: w = 0;
        2: w = $urandom_range(2, 4);
        default: w = $urandom_range(3, 16);
      endcase
      if (phase_n == 3) w = 8191;
      gentle = $urandom_range(0, 1);
      tf = pick_taps(gentle);
      tl = pick_taps(gentle);
      case ($urandom_range(0, 5))
        0: load_config(w, 0, $urandom_range(0, 3), tf, tl[47:0]);
        1: load_config(w, 8191, $urandom_range(0, 3), tf, tl[47:0]);
        default: load_config(w, $urandom_range(1, 4), $urandom_range(0, 3), tf, tl[47:0]);
      endcase
      eff = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
      if (phase_n == 3) begin
        n = $urandom_range(8, 24);
        queue_samples(n);
        rand_n += n;
      end else begin
        n = $urandom_range(1, 4) * eff;
        if (eff > 1 && $urandom_range(0, 4) == 0) n -= $urandom_range(1, eff - 1);
        queue_samples(n);
        rand_n += n;
      end
      if (rand_n > RANDOM_SAMPLES * 3 / 4) calm = 1'b1;
    end

    settle();
    repeat (4) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
